FILE: design/sfft_pkg.sv
package sfft_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrBits = 10;
  localparam int CntBits = 11;
  localparam int SampleBits = 16;
  localparam int TwBits = 18;
  localparam int TwFrac = TwBits - 2;
  localparam int CordicSteps = 24;
  localparam int CordicX0 = 652032874;
  localparam int WordBits = 64;

  localparam logic [1:0] RegInvert = 2'd0;
  localparam logic [1:0] RegScale = 2'd1;
  localparam logic [1:0] RegLog2 = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpFetch = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REV_RD, ST_REV_W1, ST_REV_W2, ST_REV_W3, ST_TW, ST_CORDIC,
    ST_BF_RD0, ST_BF_RD1, ST_BF_MUL, ST_BF_ADD, ST_BF_WR, ST_DIV_RD, ST_DIV_WR,
    ST_FETCH
  } fsm_t;

  typedef struct packed {
    logic signed [TwBits-1:0] c;
    logic signed [TwBits-1:0] s;
  } twiddle_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933405;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335086;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;     5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;       5'd21: v = 32'd325;
      5'd22: v = 32'd162;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

FILE: design/sfft_ram.sv
module sfft_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/sfft_cordic.sv
module sfft_cordic (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [31:0]             phase,
  output logic                    done,
  output sfft_pkg::twiddle_t      tw
);
  logic signed [33:0] x, y, z;
  logic [4:0] step;
  logic flip, run;
  logic signed [33:0] dx, dy, at;
  logic signed [33:0] xr, yr;
  logic signed [18:0] cr, sr;
  logic [31:0] p;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = $signed({2'b00, sfft_pkg::atan_turn(step)});
  assign p = (phase[31:30] == 2'd1 || phase[31:30] == 2'd2) ? (phase ^ 32'h80000000) : phase;
  assign xr = (x + 34'sd8192) >>> 14;
  assign yr = (y + 34'sd8192) >>> 14;

  always_comb begin
    cr = (xr > 34'sd65536) ? 19'sd65536 : (xr < -34'sd65536) ? -19'sd65536 : xr[18:0];
    sr = (yr > 34'sd65536) ? 19'sd65536 : (yr < -34'sd65536) ? -19'sd65536 : yr[18:0];
    if (flip) begin
      cr = -cr;
      sr = -sr;
    end
    tw.c = cr[sfft_pkg::TwBits-1:0];
    tw.s = sr[sfft_pkg::TwBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        step <= '0;
        flip <= (phase[31:30] == 2'd1 || phase[31:30] == 2'd2);
        x <= 34'(sfft_pkg::CordicX0);
        y <= '0;
        z <= {{2{p[31]}}, p};
      end else if (run) begin
        if (z >= 0) begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end
        if (step == 5'(sfft_pkg::CordicSteps - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run)) else $error("cordic done without run");
  a_no_go_busy: assert property (@(posedge clk) disable iff (rst)
    (run && !done) |-> !done || run) else $error("cordic state");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("cordic done held");
`endif
endmodule

FILE: design/scaled_radix2_fft.sv
// Loads are taken one per cycle while busy is low. The last load of a frame starts the
// transform, with busy high throughout: a bit-reversal pass (two reads and two writes
// per swap), one CORDIC run for each of the n-1-log2(n) nonzero twiddles, and two reads,
// a multiply and two writes per butterfly; inverse mode adds a rounding divide-by-n pass.
// A fetch passes through ST_FETCH and its result is registered and strobed as it leaves.
// Reset (rst, synchronous) clears counters, frame state, config and strobe, not memory.
module scaled_radix2_fft (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  output logic               strobe,
  output logic signed [31:0] result_re,
  output logic signed [31:0] result_im,
  output logic               last,
  output logic               valid_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  localparam int AB = sfft_pkg::AddrBits;
  localparam int CB = sfft_pkg::CntBits;

  logic invert_mode;
  logic signed [23:0] scale_factor;
  logic [3:0] log2_points;
  logic [CB-1:0] load_count, fetch_count;
  logic frame_ready;
  logic [3:0] frame_log2;

  sfft_pkg::fsm_t fsm, fsm_next;

  logic we;
  logic [AB-1:0] waddr, raddr;
  logic [63:0] wdata, rdata;

  logic [3:0] lg, st;
  logic [CB-1:0] idx, grp, jj;
  logic [AB-1:0] ia, ib;
  logic [63:0] ua, ub;
  logic signed [33:0] vr, vi;
  logic signed [49:0] p0, p1, p2, p3;
  logic [31:0] phase;
  logic cgo, cdone;
  sfft_pkg::twiddle_t tw, twr;

  logic [3:0] eff_lg;
  always_comb begin
    eff_lg = log2_points;
    if (eff_lg < 4'd1) eff_lg = 4'd1;
    if (eff_lg > 4'(AB)) eff_lg = 4'(AB);
  end

  function automatic logic [AB-1:0] bitrev(input logic [AB-1:0] v, input logic [3:0] l);
    logic [AB-1:0] r;
    r = '0;
    for (int k = 0; k < AB; k++) begin
      if (4'(k) < l) r[4'(l - 4'd1 - 4'(k))] = v[k];
    end
    return r;
  endfunction

  logic [CB-1:0] npts, half, lenc;
  assign npts = CB'(1) << lg;
  assign half = CB'(1) << (st - 4'd1);
  assign lenc = CB'(1) << st;

  logic signed [47:0] prod;
  assign prod = 48'(scale_factor) * $signed({1'b0, jj});
  always_comb begin
    logic [31:0] ph;
    ph = (st <= 4'd12) ? 32'(prod << (4'd12 - st)) : 32'(prod >> (st - 4'd12));
    phase = invert_mode ? (32'd0 - ph) : ph;
  end

  sfft_ram #(.Width(64), .Depth(sfft_pkg::MaxPoints)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  sfft_cordic u_cordic (.clk, .rst, .go(cgo), .phase, .done(cdone), .tw);

  logic signed [33:0] sr0, si0, sr1, si1;
  logic signed [32:0] hr;
  logic signed [33:0] dr, di;
  assign sr0 = 34'($signed(ua[63:32])) + vr;
  assign si0 = 34'($signed(ua[31:0])) + vi;
  assign sr1 = 34'($signed(ua[63:32])) - vr;
  assign si1 = 34'($signed(ua[31:0])) - vi;
  assign hr = 33'(1) <<< (lg - 4'd1);
  assign dr = (34'($signed(rdata[63:32])) + 34'(hr)) >>> lg;
  assign di = (34'($signed(rdata[31:0])) + 34'(hr)) >>> lg;

  logic [AB-1:0] rv;
  assign rv = bitrev(idx[AB-1:0], lg);

  always_comb begin
    fsm_next = fsm;
    we = 1'b0;
    waddr = ia;
    wdata = ua;
    raddr = idx[AB-1:0];
    cgo = 1'b0;
    case (fsm)
      sfft_pkg::ST_IDLE: begin
        if (start && operation == sfft_pkg::OpLoad) begin
          we = 1'b1;
          waddr = load_count[AB-1:0];
          wdata = {32'(sample_re), 32'(sample_im)};
          if ((load_count + CB'(1)) >= (CB'(1) << eff_lg)) fsm_next = sfft_pkg::ST_REV_RD;
        end else if (start) begin
          raddr = fetch_count[AB-1:0];
          fsm_next = sfft_pkg::ST_FETCH;
        end
      end
      sfft_pkg::ST_REV_RD: begin
        raddr = idx[AB-1:0];
        fsm_next = (idx >= npts) ? sfft_pkg::ST_TW :
                   (idx[AB-1:0] < rv) ? sfft_pkg::ST_REV_W1 : sfft_pkg::ST_REV_RD;
      end
      sfft_pkg::ST_REV_W1: begin
        raddr = rv;
        fsm_next = sfft_pkg::ST_REV_W2;
      end
      sfft_pkg::ST_REV_W2: begin
        we = 1'b1; waddr = rv; wdata = ua;
        fsm_next = sfft_pkg::ST_REV_W3;
      end
      sfft_pkg::ST_REV_W3: begin
        we = 1'b1; waddr = idx[AB-1:0]; wdata = ua;
        fsm_next = sfft_pkg::ST_REV_RD;
      end
      sfft_pkg::ST_TW: begin
        if (st > lg) fsm_next = invert_mode ? sfft_pkg::ST_DIV_RD : sfft_pkg::ST_IDLE;
        else if (jj >= half) fsm_next = sfft_pkg::ST_TW;
        else begin
          cgo = (jj != '0);
          fsm_next = (jj != '0) ? sfft_pkg::ST_CORDIC : sfft_pkg::ST_BF_RD0;
        end
      end
      sfft_pkg::ST_CORDIC: if (cdone) fsm_next = sfft_pkg::ST_BF_RD0;
      sfft_pkg::ST_BF_RD0: begin
        raddr = ia;
        fsm_next = sfft_pkg::ST_BF_RD1;
      end
      sfft_pkg::ST_BF_RD1: begin
        raddr = ib;
        fsm_next = sfft_pkg::ST_BF_MUL;
      end
      sfft_pkg::ST_BF_MUL: fsm_next = sfft_pkg::ST_BF_ADD;
      sfft_pkg::ST_BF_ADD: begin
        we = 1'b1; waddr = ia;
        wdata = {sfft_pkg::sat32(sr0), sfft_pkg::sat32(si0)};
        fsm_next = sfft_pkg::ST_BF_WR;
      end
      sfft_pkg::ST_BF_WR: begin
        we = 1'b1; waddr = ib; wdata = ub;
        fsm_next = ((grp + lenc) >= npts) ? sfft_pkg::ST_TW : sfft_pkg::ST_BF_RD0;
      end
      sfft_pkg::ST_DIV_RD: begin
        raddr = idx[AB-1:0];
        fsm_next = (idx >= npts) ? sfft_pkg::ST_IDLE : sfft_pkg::ST_DIV_WR;
      end
      sfft_pkg::ST_DIV_WR: begin
        we = 1'b1; waddr = idx[AB-1:0]; wdata = {dr[31:0], di[31:0]};
        raddr = idx[AB-1:0] + AB'(1);
        fsm_next = sfft_pkg::ST_DIV_RD;
      end
      sfft_pkg::ST_FETCH: fsm_next = sfft_pkg::ST_IDLE;
      default: fsm_next = sfft_pkg::ST_IDLE;
    endcase
  end

  assign busy = (fsm != sfft_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= sfft_pkg::ST_IDLE;
      invert_mode <= 1'b0;
      scale_factor <= 24'sd1048576;
      log2_points <= 4'd10;
      load_count <= '0;
      fetch_count <= '0;
      frame_ready <= 1'b0;
      frame_log2 <= 4'd1;
      strobe <= 1'b0;
    end else begin
      fsm <= fsm_next;
      strobe <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          sfft_pkg::RegInvert: invert_mode <= cfg_data[0];
          sfft_pkg::RegScale: scale_factor <= cfg_data;
          sfft_pkg::RegLog2: log2_points <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (fsm)
        sfft_pkg::ST_IDLE: begin
          if (start && operation == sfft_pkg::OpLoad) begin
            frame_ready <= 1'b0;
            fetch_count <= '0;
            if ((load_count + CB'(1)) >= (CB'(1) << eff_lg)) begin
              load_count <= '0;
              lg <= eff_lg;
              idx <= '0;
            end else begin
              load_count <= (load_count[AB-1:0] == AB'(sfft_pkg::MaxPoints - 1)) ?
                            CB'(0) : load_count + CB'(1);
            end
          end
        end
        sfft_pkg::ST_REV_RD: begin
          if (idx >= npts) begin
            st <= 4'd1; jj <= '0;
          end
          if (!(idx[AB-1:0] < rv) || idx >= npts) idx <= idx + CB'(1);
          if (idx >= npts) idx <= '0;
        end
        sfft_pkg::ST_REV_W1: ua <= rdata;
        sfft_pkg::ST_REV_W2: begin
          ua <= rdata;
          ia <= idx[AB-1:0];
        end
        sfft_pkg::ST_REV_W3: idx <= idx + CB'(1);
        sfft_pkg::ST_TW: begin
          if (st <= lg) begin
            if (jj >= half) begin
              st <= st + 4'd1; jj <= '0;
            end else begin
              grp <= '0;
              ia <= jj[AB-1:0];
              ib <= AB'(jj + half);
              twr <= '{c: 18'sd65536, s: '0};
            end
          end else begin
            idx <= '0;
            frame_ready <= ~invert_mode;
            frame_log2 <= lg;
            fetch_count <= '0;
          end
        end
        sfft_pkg::ST_CORDIC: if (cdone) twr <= tw;
        sfft_pkg::ST_BF_RD1: ua <= rdata;
        sfft_pkg::ST_BF_MUL: begin
          ub <= rdata;
          p0 <= $signed(rdata[63:32]) * twr.c;
          p1 <= $signed(rdata[31:0]) * twr.s;
          p2 <= $signed(rdata[63:32]) * twr.s;
          p3 <= $signed(rdata[31:0]) * twr.c;
        end
        sfft_pkg::ST_BF_ADD: begin
          ub <= {sfft_pkg::sat32(sr1), sfft_pkg::sat32(si1)};
        end
        sfft_pkg::ST_BF_WR: begin
          if ((grp + lenc) >= npts) jj <= jj + CB'(1);
          else begin
            grp <= grp + lenc;
            ia <= AB'(grp + lenc + jj);
            ib <= AB'(grp + lenc + jj + half);
          end
        end
        sfft_pkg::ST_DIV_RD: if (idx >= npts) begin
          frame_ready <= 1'b1; frame_log2 <= lg; fetch_count <= '0;
        end
        sfft_pkg::ST_DIV_WR: idx <= idx + CB'(1);
        sfft_pkg::ST_FETCH: begin
          if (frame_ready) begin
            strobe <= 1'b1;
            valid_res <= 1'b1;
            result_re <= rdata[63:32];
            result_im <= rdata[31:0];
            last <= (fetch_count == (CB'(1) << frame_log2) - CB'(1));
            if (fetch_count == (CB'(1) << frame_log2) - CB'(1)) begin
              frame_ready <= 1'b0; fetch_count <= '0;
            end else fetch_count <= fetch_count + CB'(1);
          end else begin
            strobe <= 1'b1; result_re <= '0; result_im <= '0;
            last <= 1'b0; valid_res <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  logic signed [50:0] mr, mi;
  assign mr = 51'(p0) - 51'(p1) + 51'sd32768;
  assign mi = 51'(p2) + 51'(p3) + 51'sd32768;
  always_comb begin
    if (jj == '0) begin
      vr = 34'($signed(ub[63:32]));
      vi = 34'($signed(ub[31:0]));
    end else begin
      vr = 34'(mr >>> sfft_pkg::TwFrac);
      vi = 34'(mi >>> sfft_pkg::TwFrac);
    end
  end

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(fsm == sfft_pkg::ST_FETCH || fsm == sfft_pkg::ST_IDLE))
    else $error("strobe outside fetch");
  a_valid_ready: assert property (@(posedge clk) disable iff (rst)
    (strobe && valid_res) |-> $past(frame_ready)) else $error("valid without frame");
  a_no_write_fetch: assert property (@(posedge clk) disable iff (rst)
    (fsm == sfft_pkg::ST_FETCH) |-> !we) else $error("write during fetch");
`endif
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  localparam int QuietLimit = 400000;

  class fft_scoreboard;
    typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               fin;
      logic               ok;
    } point_t;

    static const logic [31:0] AtanTurns [24] = '{
      32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
      32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81};

    longint frame_re [sfft_pkg::MaxPoints];
    longint frame_im [sfft_pkg::MaxPoints];
    int unsigned load_count, fetch_count, ready_log2;
    bit ready;
    bit invert;
    logic [23:0] scale;
    logic [3:0] log2_reg;
    point_t points_due [$];
    int mismatches;

    function new();
      load_count = 0;
      fetch_count = 0;
      ready = 0;
      ready_log2 = 1;
      invert = 0;
      scale = 24'd1048576;
      log2_reg = 4'd10;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        sfft_pkg::RegInvert: invert = data[0];
        sfft_pkg::RegScale: scale = data;
        sfft_pkg::RegLog2: log2_reg = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_log2();
      int unsigned lg;
      lg = log2_reg;
      if (lg < 1) lg = 1;
      while (lg > 1 && (1 << lg) > sfft_pkg::MaxPoints) lg--;
      return lg;
    endfunction

    function longint round_twiddle(longint v);
      longint r;
      r = (v + (64'sd1 <<< 13)) >>> 14;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r;
    endfunction

    function void rotate(logic [31:0] phase, output longint c, output longint s);
      bit flip;
      logic [31:0] p;
      longint x, y, z, dx, dy;
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      p = flip ? (phase ^ 32'h80000000) : phase;
      z = longint'($signed(p));
      x = sfft_pkg::CordicX0;
      y = 0;
      for (int i = 0; i < sfft_pkg::CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(AtanTurns[i]);
        end else begin
          x += dx; y -= dy; z += longint'(AtanTurns[i]);
        end
      end
      c = round_twiddle(x);
      s = round_twiddle(y);
      if (flip) begin
        c = -c; s = -s;
      end
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void run_transform(int unsigned lg);
      int unsigned n, r, len, half;
      longint sc, wc, ws, vr, vi, ur, ui, br, bi, t, hr;
      logic [63:0] prod;
      logic [31:0] phase;
      n = 1 << lg;
      sc = longint'($signed(scale));
      for (int unsigned i = 0; i < n; i++) begin
        r = 0;
        for (int unsigned k = 0; k < lg; k++) r |= ((i >> k) & 1) << (lg - 1 - k);
        if (i < r) begin
          t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
          t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
        end
      end
      for (int unsigned st = 1; st <= lg; st++) begin
        len = 1 << st;
        half = len >> 1;
        for (int unsigned j = 0; j < half; j++) begin
          prod = sc * longint'(j);
          phase = 32'(prod << (12 - st));
          if (invert) phase = 32'd0 - phase;
          wc = 0;
          ws = 0;
          if (j != 0) rotate(phase, wc, ws);
          for (int unsigned i = 0; i < n; i += len) begin
            ur = frame_re[i + j]; ui = frame_im[i + j];
            br = frame_re[i + j + half]; bi = frame_im[i + j + half];
            if (j == 0) begin
              vr = br; vi = bi;
            end else begin
              vr = (br * wc - bi * ws + (64'sd1 <<< (sfft_pkg::TwFrac - 1))) >>>
                   sfft_pkg::TwFrac;
              vi = (br * ws + bi * wc + (64'sd1 <<< (sfft_pkg::TwFrac - 1))) >>>
                   sfft_pkg::TwFrac;
            end
            frame_re[i + j] = clip32(ur + vr);
            frame_im[i + j] = clip32(ui + vi);
            frame_re[i + j + half] = clip32(ur - vr);
            frame_im[i + j + half] = clip32(ui - vi);
          end
        end
      end
      if (invert) begin
        hr = 64'sd1 <<< (lg - 1);
        for (int unsigned i = 0; i < n; i++) begin
          frame_re[i] = longint'($signed(32'((frame_re[i] + hr) >>> lg)));
          frame_im[i] = longint'($signed(32'((frame_im[i] + hr) >>> lg)));
        end
      end
    endfunction

    function void note_item(logic op, logic signed [15:0] re, logic signed [15:0] im);
      int unsigned lg, idx, n;
      point_t pt;
      if (op == sfft_pkg::OpLoad) begin
        lg = active_log2();
        idx = load_count % sfft_pkg::MaxPoints;
        if (ready) begin
          ready = 0; fetch_count = 0;
        end
        frame_re[idx] = re;
        frame_im[idx] = im;
        load_count = idx + 1;
        if (load_count >= (1 << lg)) begin
          run_transform(lg);
          ready_log2 = lg;
          load_count = 0;
          fetch_count = 0;
          ready = 1;
        end
        return;
      end
      pt = '{re: 0, im: 0, fin: 0, ok: 0};
      if (ready) begin
        n = 1 << ready_log2;
        idx = fetch_count % n;
        pt.re = 32'(frame_re[idx]);
        pt.im = 32'(frame_im[idx]);
        pt.fin = (idx == n - 1);
        pt.ok = 1;
        if (pt.fin) begin
          ready = 0; fetch_count = 0;
        end else fetch_count = idx + 1;
      end
      points_due.push_back(pt);
    endfunction

    function void check_result(logic signed [31:0] re, logic signed [31:0] im,
                               logic fin, logic ok);
      point_t pt;
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result re=%0d im=%0d", re, im);
        return;
      end
      pt = points_due.pop_front();
      if (re !== pt.re || im !== pt.im || fin !== pt.fin || ok !== pt.ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp re=%0d im=%0d last=%0d valid=%0d,",
                   pt.re, pt.im, pt.fin, pt.ok,
                   " got re=%0d im=%0d last=%0d valid=%0d", re, im, fin, ok);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = sfft_pkg::OpLoad;
  logic signed [15:0] sample_re = '0;
  logic signed [15:0] sample_im = '0;
  logic strobe;
  logic signed [31:0] result_re;
  logic signed [31:0] result_im;
  logic last;
  logic valid_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = sfft_pkg::RegInvert;
  logic [23:0] cfg_data = '0;

  fft_scoreboard sb = new();
  int idle_pct = 0;
  int quiet = 0;

  scaled_radix2_fft i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .sample_re(sample_re), .sample_im(sample_im), .strobe(strobe),
    .result_re(result_re), .result_im(result_im), .last(last), .valid_res(valid_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(operation, sample_re, sample_im);
      if (strobe) sb.check_result(result_re, result_im, last, valid_res);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("scaled_radix2_fft regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [15:0] re, logic signed [15:0] im);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    sample_re <= re;
    sample_im <= im;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.points_due.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_frame(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(sfft_pkg::OpLoad, pick_sample(), pick_sample());
  endtask

  task automatic fetch_some(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(sfft_pkg::OpFetch, 16'($urandom), 16'($urandom));
  endtask

  logic        ph_inv   [17] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                                 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic [23:0] ph_scale [17] = '{24'd1048576, 24'd1048576, 24'h800000, 24'h7fffff,
                                 24'd0, 24'd524288, 24'hf00000, 24'd1048576, 24'h7fffff,
                                 24'd3145728, 24'h123456, 24'd1048576, 24'hfedcba,
                                 24'd2097152, 24'h800000, 24'd1572864, 24'hffffff};
  logic [3:0]  ph_log2  [17] = '{4'd2, 4'd3, 4'd1, 4'd4, 4'd0, 4'd5, 4'd6, 4'd3, 4'd15,
                                 4'd2, 4'd4, 4'd11, 4'd1, 4'd5, 4'd3, 4'd6, 4'd2};

  initial begin
    int unsigned n, count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 17; ph++) begin
      idle_pct = (ph < 6) ? 33 : (ph < 12) ? 56 : 0;
      write_cfg(sfft_pkg::RegInvert, {23'd0, ph_inv[ph]});
      write_cfg(sfft_pkg::RegScale, ph_scale[ph]);
      if (ph_log2[ph] == 4'd11) write_cfg(sfft_pkg::RegLog2, 24'd2);
      else write_cfg(sfft_pkg::RegLog2, {20'd0, ph_log2[ph]});
      n = 1 << sb.active_log2();
      if (ph == 0) begin
        fetch_some(1);
        send_item(sfft_pkg::OpLoad, 16'sh7fff, 16'sh8000);
        send_item(sfft_pkg::OpLoad, 16'sh8000, 16'sh7fff);
        send_item(sfft_pkg::OpLoad, 16'sh0000, 16'shffff);
        send_item(sfft_pkg::OpLoad, 16'sh7fff, 16'sh7fff);
        fetch_some(5);
        load_frame(4);
        fetch_some(2);
        send_item(sfft_pkg::OpLoad, 16'sh5555, 16'shaaaa);
        fetch_some(1);
        load_frame(3);
        fetch_some(4);
      end else if (n == sfft_pkg::MaxPoints) begin
        load_frame(5);
        drain();
        write_cfg(sfft_pkg::RegLog2, 24'd2);
        load_frame(1);
        fetch_some(5);
      end else begin
        count = 0;
        while (count < 30) begin
          if ($urandom_range(99) < 75) begin
            load_frame(n);
            fetch_some(n + $urandom_range(1));
            count += 2 * n;
          end else begin
            repeat (1 + $urandom_range(2)) begin
              send_item(logic'($urandom_range(1)), pick_sample(), pick_sample());
              count++;
            end
          end
        end
      end
      drain();
    end

    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.points_due.size() == 0) begin
      $display("scaled_radix2_fft regression: pass");
    end else begin
      $display("scaled_radix2_fft regression: fail");
    end
    $finish;
  end
endmodule
